@@ rtl/qcf_pkg.sv @@
// ----------------------------------------------------------------------------
// qcf_pkg
// Shared types and constants of the quadratic curve flattener.
// ----------------------------------------------------------------------------
package qcf_pkg;

    // segment count register and segment index widths
    localparam int CNT_W = 7;
    localparam int IDX_W = 6;

    // t is unsigned Q1.16, one whole bit above sixteen fraction bits
    localparam int T_W        = 17;
    localparam int T_FRAC     = 16;
    localparam int T_HALF     = 32768;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // remainder of the step division stays below the segment count
    localparam int REM_W = 7;

    // one quotient bit is produced per divider step
    localparam int DIV_STEPS = T_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [CNT_W-1:0] DEFAULT_SEGMENTS = 7'd20;

    // coordinates of one curve, in input order
    localparam int NUM_COORDS = 6;
    localparam int CRD_SX = 0;
    localparam int CRD_SY = 1;
    localparam int CRD_CX = 2;
    localparam int CRD_CY = 3;
    localparam int CRD_EX = 4;
    localparam int CRD_EY = 5;

    // per curve t stepping: t advances by q0 + r0/n each segment
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [T_W-1:0]   q0;
        logic [REM_W-1:0] r0;
    } t_step;

    localparam int STEP_W = $bits(t_step);

endpackage

@@ rtl/quadratic_curve_flattener_unit.sv @@
// ----------------------------------------------------------------------------
// quadratic_curve_flattener_unit
// Splits a quadratic curve into straight line segments by nested linear
// interpolation in Q12.4 coordinates.
// ----------------------------------------------------------------------------
// A curve is taken when start is high and busy low; the front then works
// out the t step with a one-bit-per-cycle divider and hands the curve to a
// two-entry queue, so busy stays high through the divide and the hand-over,
// longer while the queue is full. Up to three curves may be held while the
// back end is working. The back end takes a load state per curve, then one
// state for each of the three interpolations of a segment, which share one
// multiplier per axis. Each segment appears on the outputs for exactly one
// cycle with o_valid high and is never repeated: the receiver must take it
// then. Each segment of a curve runs through B_L1, B_L2 and B_L3 in turn.
module quadratic_curve_flattener_unit #(
    parameter int COORD_WIDTH  = 16,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [qcf_pkg::CNT_W-1:0]        i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0]    i_start_x,
    input  logic signed [COORD_WIDTH-1:0]    i_start_y,
    input  logic signed [COORD_WIDTH-1:0]    i_control_x,
    input  logic signed [COORD_WIDTH-1:0]    i_control_y,
    input  logic signed [COORD_WIDTH-1:0]    i_end_x,
    input  logic signed [COORD_WIDTH-1:0]    i_end_y,
    output logic                             o_valid,
    output logic signed [COORD_WIDTH-1:0]    o_from_x,
    output logic signed [COORD_WIDTH-1:0]    o_from_y,
    output logic signed [COORD_WIDTH-1:0]    o_to_x,
    output logic signed [COORD_WIDTH-1:0]    o_to_y,
    output logic [qcf_pkg::IDX_W-1:0]        o_segment_index,
    output logic                             o_last_segment
);

    localparam int PTS_W = qcf_pkg::NUM_COORDS * COORD_WIDTH;
    localparam int Q_W   = PTS_W + qcf_pkg::STEP_W;

    logic [qcf_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]    in_pts;
    logic [qcf_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]    f_pts;
    logic [qcf_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]    b_pts;
    qcf_pkg::t_step                                     f_step;
    qcf_pkg::t_step                                     b_step;
    logic                                               q_push;
    logic                                               q_pop;
    logic                                               q_full;
    logic                                               q_empty;
    logic [Q_W-1:0]                                     q_wdata;
    logic [Q_W-1:0]                                     q_rdata;
    logic [COORD_WIDTH-1:0]                             from_x, from_y, to_x, to_y;

    assign in_pts[qcf_pkg::CRD_SX] = i_start_x;
    assign in_pts[qcf_pkg::CRD_SY] = i_start_y;
    assign in_pts[qcf_pkg::CRD_CX] = i_control_x;
    assign in_pts[qcf_pkg::CRD_CY] = i_control_y;
    assign in_pts[qcf_pkg::CRD_EX] = i_end_x;
    assign in_pts[qcf_pkg::CRD_EY] = i_end_y;

    // accept curves and prepare the t step
    qcf_front #(
        .COORD_WIDTH  (COORD_WIDTH),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_points    (in_pts),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_points    (f_pts),
        .o_step      (f_step)
    );

    // buffer prepared curves
    assign q_wdata = {f_pts, f_step};

    qcf_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    assign b_pts  = q_rdata[Q_W-1:qcf_pkg::STEP_W];
    assign b_step = q_rdata[qcf_pkg::STEP_W-1:0];

    // evaluate and emit segments
    qcf_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .o_pop           (q_pop),
        .i_points        (b_pts),
        .i_step          (b_step),
        .o_valid         (o_valid),
        .o_from_x        (from_x),
        .o_from_y        (from_y),
        .o_to_x          (to_x),
        .o_to_y          (to_y),
        .o_segment_index (o_segment_index),
        .o_last_segment  (o_last_segment)
    );

    assign o_from_x = from_x;
    assign o_from_y = from_y;
    assign o_to_x   = to_x;
    assign o_to_y   = to_y;

`ifndef NO_ASSERTIONS
    // the queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("curve queue written while full");

    // a taken curve keeps the front busy while it divides
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("front took a curve but did not go busy");

    // segment strobes never fall on consecutive cycles
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("segment strobes on consecutive cycles");

    // a segment that is not the last of its curve is followed by the next one
    a_segment_cadence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_segment) |=> ##2 o_valid)
        else $error("next segment of a curve not emitted on time");
`endif

endmodule

@@ rtl/qcf_front.sv @@
// ----------------------------------------------------------------------------
// qcf_front
// Accepts a curve, clamps the segment count and works out the t step
// 65536 / n with a restoring divider, then pushes the curve to the queue.
// ----------------------------------------------------------------------------
module qcf_front #(
    parameter int COORD_WIDTH  = 16,
    parameter int MAX_SEGMENTS = 64
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                start,
    output logic                                                busy,
    input  logic                                                i_cfg_valid,
    output logic                                                o_cfg_ready,
    input  logic [qcf_pkg::CNT_W-1:0]                           i_cfg_data,
    input  logic [qcf_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]     i_points,
    input  logic                                                i_q_full,
    output logic                                                o_push,
    output logic [qcf_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]     o_points,
    output qcf_pkg::t_step                                      o_step
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    t_front_state                                       r_state, n_state;
    logic [qcf_pkg::CNT_W-1:0]                          r_seg;
    logic [qcf_pkg::CNT_W-1:0]                          r_n;
    logic [qcf_pkg::T_W-1:0]                            r_dvd;
    logic [qcf_pkg::REM_W-1:0]                          r_rem;
    logic [qcf_pkg::DIV_CNT_W-1:0]                      r_cnt;
    logic [qcf_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0]    r_pts;
    logic [qcf_pkg::CNT_W-1:0]                          n_clamped;
    logic [qcf_pkg::REM_W:0]                            rem_sh;
    logic                                               rem_ge;
    logic                                               accept;

    assign accept      = start && (r_state == F_IDLE);
    assign busy        = (r_state != F_IDLE);
    assign o_cfg_ready = 1'b1;

    // clamp the segment count into one..MAX_SEGMENTS
    always_comb begin
        if (r_seg == '0) begin
            n_clamped = qcf_pkg::CNT_W'(1);
        end else if (r_seg > qcf_pkg::CNT_W'(MAX_SEGMENTS)) begin
            n_clamped = qcf_pkg::CNT_W'(MAX_SEGMENTS);
        end else begin
            n_clamped = r_seg;
        end
    end

    // one restoring divider step: bring down the next dividend bit
    assign rem_sh = {r_rem, r_dvd[qcf_pkg::T_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, r_n});

    // sequence accept, divide and push
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (start) begin
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                if (r_cnt == qcf_pkg::DIV_CNT_W'(qcf_pkg::DIV_STEPS - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // hold the segment count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg <= qcf_pkg::DEFAULT_SEGMENTS;
        end else if (i_cfg_valid) begin
            r_seg <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the curve and run the divider
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pts <= i_points;
            r_n   <= n_clamped;
            r_dvd <= qcf_pkg::T_ONE;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == F_DIV) begin
            r_dvd <= {r_dvd[qcf_pkg::T_W-2:0], rem_ge};
            r_rem <= rem_ge ? qcf_pkg::REM_W'(rem_sh - {1'b0, r_n})
                            : qcf_pkg::REM_W'(rem_sh);
            r_cnt <= r_cnt + qcf_pkg::DIV_CNT_W'(1);
        end
    end

    assign o_push     = (r_state == F_PUSH) && !i_q_full;
    assign o_points   = r_pts;
    assign o_step.n   = r_n;
    assign o_step.q0  = r_dvd;
    assign o_step.r0  = r_rem;

endmodule

@@ rtl/qcf_queue.sv @@
// ----------------------------------------------------------------------------
// qcf_queue
// Two-entry queue of prepared curves between front and back.
// ----------------------------------------------------------------------------
module qcf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // store pushed beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/qcf_back.sv @@
// ----------------------------------------------------------------------------
// qcf_back
// Walks a queued curve segment by segment: three interpolations per point
// on one multiplier per axis, then emits the segment for one cycle.
// ----------------------------------------------------------------------------
module qcf_back #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_q_empty,
    output logic                                            o_pop,
    input  logic [qcf_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] i_points,
    input  qcf_pkg::t_step                                  i_step,
    output logic                                            o_valid,
    output logic [COORD_WIDTH-1:0]                          o_from_x,
    output logic [COORD_WIDTH-1:0]                          o_from_y,
    output logic [COORD_WIDTH-1:0]                          o_to_x,
    output logic [COORD_WIDTH-1:0]                          o_to_y,
    output logic [qcf_pkg::IDX_W-1:0]                       o_segment_index,
    output logic                                            o_last_segment
);

    localparam int CW    = COORD_WIDTH;
    localparam int PW    = CW + qcf_pkg::T_W + 2;
    localparam int LANES = 2;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_L1   = 4'b0010,
        B_L2   = 4'b0100,
        B_L3   = 4'b1000
    } t_back_state;

    t_back_state                                        r_state, n_state;
    logic [qcf_pkg::NUM_COORDS-1:0][CW-1:0]             r_pts;
    logic [qcf_pkg::CNT_W-1:0]                          r_n;
    logic [qcf_pkg::T_W-1:0]                            r_q0;
    logic [qcf_pkg::REM_W-1:0]                          r_r0;
    logic [qcf_pkg::T_W-1:0]                            r_t;
    logic [qcf_pkg::REM_W-1:0]                          r_rem;
    logic [qcf_pkg::IDX_W-1:0]                          r_idx;
    logic [CW-1:0]                                      r_l1   [LANES];
    logic [CW-1:0]                                      r_l2   [LANES];
    logic [CW-1:0]                                      r_prev [LANES];

    logic [CW-1:0]                                      la     [LANES];
    logic [CW-1:0]                                      lb     [LANES];
    logic signed [CW:0]                                 ldiff  [LANES];
    logic signed [PW-1:0]                               lprod  [LANES];
    logic signed [PW-1:0]                               lsum   [LANES];
    logic [CW-1:0]                                      lres   [LANES];
    logic signed [qcf_pkg::T_W:0]                       t_s;
    logic [qcf_pkg::REM_W:0]                            rem_sum;
    logic                                               rem_wrap;
    logic                                               is_last;

    assign o_pop   = (r_state == B_IDLE) && !i_q_empty;
    assign t_s     = $signed({1'b0, r_t});
    assign is_last = ({1'b0, r_idx} + qcf_pkg::CNT_W'(1)) == r_n;

    // interpolate a toward b by t on each axis, rounding to nearest
    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            unique case (r_state)
                B_L1: begin
                    la[k] = r_pts[qcf_pkg::CRD_SX + k];
                    lb[k] = r_pts[qcf_pkg::CRD_CX + k];
                end
                B_L2: begin
                    la[k] = r_pts[qcf_pkg::CRD_CX + k];
                    lb[k] = r_pts[qcf_pkg::CRD_EX + k];
                end
                default: begin
                    la[k] = r_l1[k];
                    lb[k] = r_l2[k];
                end
            endcase
            ldiff[k] = $signed({lb[k][CW-1], lb[k]}) - $signed({la[k][CW-1], la[k]});
            lprod[k] = ldiff[k] * t_s;
            lsum[k]  = lprod[k] + $signed(PW'(qcf_pkg::T_HALF));
            lres[k]  = la[k] + lsum[k][CW+qcf_pkg::T_FRAC-1:qcf_pkg::T_FRAC];
        end
    end

    // step t by q0 and carry the remainder into the next whole unit
    assign rem_sum  = {1'b0, r_rem} + {1'b0, r_r0};
    assign rem_wrap = (rem_sum >= {1'b0, r_n});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = B_L1;
                end
            end
            B_L1: n_state = B_L2;
            B_L2: n_state = B_L3;
            B_L3: n_state = is_last ? B_IDLE : B_L1;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == B_L3);
        end
    end

    // load a curve, hold partial results, advance the segment
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    r_pts     <= i_points;
                    r_n       <= i_step.n;
                    r_q0      <= i_step.q0;
                    r_r0      <= i_step.r0;
                    r_t       <= i_step.q0;
                    r_rem     <= i_step.r0;
                    r_idx     <= '0;
                    r_prev[0] <= i_points[qcf_pkg::CRD_SX];
                    r_prev[1] <= i_points[qcf_pkg::CRD_SY];
                end
            end
            B_L1: begin
                for (int k = 0; k < LANES; k++) begin
                    r_l1[k] <= lres[k];
                end
            end
            B_L2: begin
                for (int k = 0; k < LANES; k++) begin
                    r_l2[k] <= lres[k];
                end
            end
            B_L3: begin
                for (int k = 0; k < LANES; k++) begin
                    r_prev[k] <= lres[k];
                end
                o_from_x        <= r_prev[0];
                o_from_y        <= r_prev[1];
                o_to_x          <= lres[0];
                o_to_y          <= lres[1];
                o_segment_index <= r_idx;
                o_last_segment  <= is_last;
                r_idx           <= r_idx + qcf_pkg::IDX_W'(1);
                r_t             <= r_t + r_q0 + qcf_pkg::T_W'(rem_wrap);
                r_rem           <= rem_wrap ? qcf_pkg::REM_W'(rem_sum - {1'b0, r_n})
                                            : qcf_pkg::REM_W'(rem_sum);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

endmodule
